>>> src/flm_pkg.sv
// Package for the FIFO lock manager: request and event types, event codes,
// controller states and datapath commands. Depends on nothing.
`timescale 1ns / 1ps
package flm_pkg;

	typedef struct packed {
		logic       req_type;
		logic [3:0] proc_id;
		logic [2:0] res_id;
	} flm_req_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [3:0] proc_out;
		logic [2:0] res_out;
		logic       last;
	} flm_evt_t;

	localparam logic REQ_LOCK = 1'b0;
	localparam logic REQ_EXIT = 1'b1;

	localparam logic [2:0] EV_ACQUIRED        = 3'd0;
	localparam logic [2:0] EV_HELD            = 3'd1;
	localparam logic [2:0] EV_ALREADY_PENDING = 3'd2;
	localparam logic [2:0] EV_PENDING         = 3'd3;
	localparam logic [2:0] EV_EXITING         = 3'd4;
	localparam logic [2:0] EV_RELEASING       = 3'd5;
	localparam logic [2:0] EV_NO_WAITERS      = 3'd6;
	localparam logic [2:0] EV_EXIT_UNACQUIRED = 3'd7;

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_LK_RD, S_LK_DEC, S_FLUSH, S_EX_START, S_EX_LOOP,
		S_EX_CHK, S_EX_HEAD, S_SR_RD, S_SR_CMP, S_SH_RD, S_SH_WR, S_GR_RD,
		S_GR_EMIT, S_NW
	} flm_state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LATCH, OP_LK_RD, OP_LK_DEC, OP_FLUSH, OP_EX_START,
		OP_EX_LOOP, OP_EX_CHK, OP_EX_HEAD, OP_SR_RD, OP_SR_CMP, OP_SH_RD,
		OP_SH_WR, OP_SH_END, OP_GR_RD, OP_GR_EMIT, OP_NW
	} flm_op_t;

	typedef struct packed {
		logic in_range;
		logic is_exit;
		logic out_free;
		logic j_zero;
		logic rr_ok;
		logic head_is_p;
		logic srch_end;
		logic match;
		logic shift_more;
		logic len_one;
		logic rel;
	} flm_status_t;

endpackage

>>> src/flm_ctrl.sv
// Controller state machine of the FIFO lock manager.
// Depends on flm_pkg; drives commands into flm_datapath.
`timescale 1ns / 1ps
module flm_ctrl import flm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  flm_status_t status,
	output flm_op_t     op
);

	flm_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		op        = OP_NONE;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					op        = OP_LATCH;
					state_nxt = S_DISP;
				end
			end
			S_DISP: begin
				if (!status.in_range) state_nxt = S_IDLE;
				else if (status.is_exit) state_nxt = S_EX_START;
				else state_nxt = S_LK_RD;
			end
			S_LK_RD: begin
				op        = OP_LK_RD;
				state_nxt = S_LK_DEC;
			end
			S_LK_DEC: begin
				if (status.out_free) begin
					op        = OP_LK_DEC;
					state_nxt = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (status.out_free) begin
					op        = OP_FLUSH;
					state_nxt = S_IDLE;
				end
			end
			S_EX_START: begin
				if (status.out_free) begin
					op        = OP_EX_START;
					state_nxt = S_EX_LOOP;
				end
			end
			S_EX_LOOP: begin
				if (status.j_zero) begin
					state_nxt = S_FLUSH;
				end else begin
					op        = OP_EX_LOOP;
					state_nxt = S_EX_CHK;
				end
			end
			S_EX_CHK: begin
				if (status.rr_ok) begin
					op        = OP_EX_CHK;
					state_nxt = S_EX_HEAD;
				end else begin
					state_nxt = S_EX_LOOP;
				end
			end
			S_EX_HEAD: begin
				if (status.out_free) begin
					op        = OP_EX_HEAD;
					state_nxt = status.head_is_p ? S_SH_RD : S_SR_RD;
				end
			end
			S_SR_RD: begin
				if (status.srch_end) begin
					state_nxt = S_EX_LOOP;
				end else begin
					op        = OP_SR_RD;
					state_nxt = S_SR_CMP;
				end
			end
			S_SR_CMP: begin
				op        = OP_SR_CMP;
				state_nxt = status.match ? S_SH_RD : S_SR_RD;
			end
			S_SH_RD: begin
				if (status.shift_more) begin
					op        = OP_SH_RD;
					state_nxt = S_SH_WR;
				end else begin
					op = OP_SH_END;
					if (!status.rel) state_nxt = S_EX_LOOP;
					else if (status.len_one) state_nxt = S_NW;
					else state_nxt = S_GR_RD;
				end
			end
			S_SH_WR: begin
				op        = OP_SH_WR;
				state_nxt = S_SH_RD;
			end
			S_GR_RD: begin
				op        = OP_GR_RD;
				state_nxt = S_GR_EMIT;
			end
			S_GR_EMIT: begin
				if (status.out_free) begin
					op        = OP_GR_EMIT;
					state_nxt = S_EX_LOOP;
				end
			end
			S_NW: begin
				if (status.out_free) begin
					op        = OP_NW;
					state_nxt = S_EX_LOOP;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

>>> src/flm_datapath.sv
// Datapath of the FIFO lock manager: wait queues, request lists, membership
// bits, counters and the event staging and output registers. Depends on flm_pkg.
`timescale 1ns / 1ps
module flm_datapath import flm_pkg::*; #(
	parameter int NUM_PROCS = 16,
	parameter int NUM_RES   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  flm_op_t     op,
	input  flm_req_t    req_data,
	output flm_status_t status,
	output logic        evt_valid,
	input  logic        evt_ready,
	output flm_evt_t    evt_data
);

	localparam int PW  = $clog2(NUM_PROCS);
	localparam int LW  = $clog2(NUM_PROCS + 1);
	localparam int RIW = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
	localparam int CW  = $clog2(NUM_RES + 1);

	logic [3:0]    wq_mem [NUM_RES][NUM_PROCS];
	logic [2:0]    rl_mem [NUM_PROCS][NUM_RES];
	logic [LW-1:0] qlen_q [NUM_RES];
	logic [NUM_PROCS-1:0] mm_q [NUM_RES];
	logic [CW-1:0] rc_q [NUM_PROCS];

	logic          typ_q;
	logic [3:0]    p_q;
	logic [2:0]    r_q;
	logic [CW-1:0] j_q;
	logic [LW-1:0] i_q;
	logic          rel_q;
	logic [3:0]    wq_rd_q;
	logic [2:0]    rl_rd_q;
	logic          st_vld_q;
	flm_evt_t      st_q;
	logic          out_vld_q;
	flm_evt_t      out_q;

	logic [7:0]     p_ext, r_ext, rr_ext;
	logic [PW-1:0]  pi;
	logic [RIW-1:0] ri, rri;
	logic [LW-1:0]  len_lk, len_rr, i_p1;
	logic [CW-1:0]  j_m1, rc_p;
	logic           out_free;
	logic           enq;
	logic           emit_en;
	logic [2:0]     emit_ev, emit_r;
	logic [3:0]     emit_p;
	logic           wq_re;
	logic [RIW-1:0] wq_rres;
	logic [PW-1:0]  wq_rpos;

	assign p_ext  = {4'b0, p_q};
	assign r_ext  = {5'b0, r_q};
	assign rr_ext = {5'b0, rl_rd_q};
	assign pi     = p_ext[PW-1:0];
	assign ri     = r_ext[RIW-1:0];
	assign rri    = rr_ext[RIW-1:0];
	assign len_lk = qlen_q[ri];
	assign len_rr = qlen_q[rri];
	assign i_p1   = i_q + 1'b1;
	assign j_m1   = j_q - 1'b1;
	assign rc_p   = rc_q[pi];
	assign out_free = !out_vld_q || evt_ready;

	assign status.in_range   = ({5'b0, p_q} < 9'(NUM_PROCS))
		&& (typ_q == REQ_EXIT || r_ext < 8'(NUM_RES));
	assign status.is_exit    = typ_q == REQ_EXIT;
	assign status.out_free   = out_free;
	assign status.j_zero     = j_q == '0;
	assign status.rr_ok      = (rr_ext < 8'(NUM_RES)) && mm_q[rri][pi];
	assign status.head_is_p  = (len_rr != '0) && (wq_rd_q == p_q);
	assign status.srch_end   = i_q >= len_rr;
	assign status.match      = wq_rd_q == p_q;
	assign status.shift_more = i_p1 < len_rr;
	assign status.len_one    = len_rr == LW'(1);
	assign status.rel        = rel_q;

	assign enq = (len_lk == '0) || ((wq_rd_q != p_q) && !mm_q[ri][pi]);

	always_comb begin
		emit_en = 1'b0;
		emit_ev = EV_ACQUIRED;
		emit_p  = p_q;
		emit_r  = r_q;
		wq_re   = 1'b0;
		wq_rres = rri;
		wq_rpos = '0;
		case (op)
			OP_LK_RD: begin
				wq_re   = 1'b1;
				wq_rres = ri;
			end
			OP_LK_DEC: begin
				emit_en = 1'b1;
				if (len_lk == '0) emit_ev = EV_ACQUIRED;
				else if (wq_rd_q == p_q) emit_ev = EV_HELD;
				else if (mm_q[ri][pi]) emit_ev = EV_ALREADY_PENDING;
				else emit_ev = EV_PENDING;
			end
			OP_EX_START: begin
				emit_en = 1'b1;
				emit_ev = EV_EXITING;
				emit_r  = 3'd0;
			end
			OP_EX_CHK, OP_GR_RD: begin
				wq_re = 1'b1;
			end
			OP_EX_HEAD: begin
				emit_en = 1'b1;
				emit_r  = rl_rd_q;
				emit_ev = status.head_is_p ? EV_RELEASING : EV_EXIT_UNACQUIRED;
			end
			OP_SR_RD: begin
				wq_re   = 1'b1;
				wq_rpos = i_q[PW-1:0];
			end
			OP_SH_RD: begin
				wq_re   = 1'b1;
				wq_rpos = i_p1[PW-1:0];
			end
			OP_GR_EMIT: begin
				emit_en = 1'b1;
				emit_ev = EV_ACQUIRED;
				emit_p  = wq_rd_q;
				emit_r  = rl_rd_q;
			end
			OP_NW: begin
				emit_en = 1'b1;
				emit_ev = EV_NO_WAITERS;
				emit_p  = 4'd0;
				emit_r  = rl_rd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wq_re) begin
			wq_rd_q <= wq_mem[wq_rres][wq_rpos];
		end
		if (op == OP_LK_DEC && enq && len_lk < LW'(NUM_PROCS)) begin
			wq_mem[ri][len_lk[PW-1:0]] <= p_q;
		end else if (op == OP_SH_WR) begin
			wq_mem[rri][i_q[PW-1:0]] <= wq_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_EX_LOOP) begin
			rl_rd_q <= rl_mem[pi][j_m1[RIW-1:0]];
		end
		if (op == OP_LK_DEC && enq && rc_p < CW'(NUM_RES)) begin
			rl_mem[pi][rc_p[RIW-1:0]] <= r_q;
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LATCH: begin
				typ_q <= req_data.req_type;
				p_q   <= req_data.proc_id;
				r_q   <= req_data.res_id;
			end
			OP_EX_START: j_q <= rc_p;
			OP_EX_LOOP:  j_q <= j_m1;
			OP_EX_HEAD: begin
				i_q   <= '0;
				rel_q <= status.head_is_p;
			end
			OP_SR_CMP: begin
				if (!status.match) i_q <= i_p1;
			end
			OP_SH_WR: i_q <= i_p1;
			default: begin
			end
		endcase
		if (emit_en) begin
			st_q <= '{event_res: emit_ev, proc_out: emit_p, res_out: emit_r, last: 1'b0};
		end
		if (emit_en && st_vld_q) begin
			out_q <= st_q;
		end else if (op == OP_FLUSH && st_vld_q) begin
			out_q <= '{event_res: st_q.event_res, proc_out: st_q.proc_out,
				res_out: st_q.res_out, last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
			for (int k = 0; k < NUM_RES; k++) begin
				qlen_q[k] <= '0;
				mm_q[k]   <= '0;
			end
			for (int k = 0; k < NUM_PROCS; k++) begin
				rc_q[k] <= '0;
			end
		end else begin
			if (emit_en) begin
				st_vld_q <= 1'b1;
			end else if (op == OP_FLUSH) begin
				st_vld_q <= 1'b0;
			end
			if ((emit_en || op == OP_FLUSH) && st_vld_q) begin
				out_vld_q <= 1'b1;
			end else if (evt_ready) begin
				out_vld_q <= 1'b0;
			end
			case (op)
				OP_LK_DEC: begin
					if (enq) begin
						if (len_lk < LW'(NUM_PROCS)) begin
							qlen_q[ri]   <= len_lk + 1'b1;
							mm_q[ri][pi] <= 1'b1;
						end
						if (rc_p < CW'(NUM_RES)) begin
							rc_q[pi] <= rc_p + 1'b1;
						end
					end
				end
				OP_EX_HEAD: mm_q[rri][pi] <= 1'b0;
				OP_SH_END:  qlen_q[rri] <= len_rr - 1'b1;
				OP_FLUSH: begin
					if (typ_q == REQ_EXIT) rc_q[pi] <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign evt_valid = out_vld_q;
	assign evt_data  = out_q;

`ifndef NO_ASSERTIONS
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit_en |-> out_free)
		else $error("event staged while the output register is blocked");
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_FLUSH && st_vld_q) |=> (out_vld_q && out_q.last))
		else $error("flush did not present a final event");
	a_shift_len: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_SH_END) |=> (qlen_q[rri] == $past(len_rr) - 1'b1))
		else $error("queue length not reduced after removal");
	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_LATCH) |-> !st_vld_q)
		else $error("stale event left staged at a new request");
`endif

endmodule

>>> src/fifo_lock_manager.sv
// Lock manager with a FIFO waiter queue per resource; the queue head holds the
// resource. A lock request latches, dispatches, reads the queue head, decides and
// flushes its event. An exit walks every listed resource, searches a queue for the
// exiting process when it is not the head, shifts the later entries down one at a
// time on removal, ends the shift and reports the release outcome. The single
// read port of the wait-queue memory, with its registered read and entry-by-entry
// shift, carries every queue removal. A stalled event output stalls the controller.
// Events leave one per cycle at most through a registered output; the block
// takes a new request only after the previous one has produced all its events.
// Top level; depends on flm_pkg, flm_ctrl and flm_datapath.
`timescale 1ns / 1ps
module fifo_lock_manager import flm_pkg::*; #(
	parameter int NUM_PROCS = 16,
	parameter int NUM_RES   = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  flm_req_t req_data,
	output logic     evt_valid,
	input  logic     evt_ready,
	output flm_evt_t evt_data
);

	flm_op_t     op;
	flm_status_t status;

	flm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.status    (status),
		.op        (op)
	);

	flm_datapath #(
		.NUM_PROCS (NUM_PROCS),
		.NUM_RES   (NUM_RES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.req_data  (req_data),
		.status    (status),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt_data  (evt_data)
	);

endmodule
